@@ rtl/core/stbeq_pkg.sv @@
// ----------------------------------------------------------------------------
// stbeq_pkg
// Shared sizes, formats and command codes of the stereo biquad equalizer.
// ----------------------------------------------------------------------------
package stbeq_pkg;

   localparam int SAMPLE_BITS     = 24;
   localparam int COEF_BITS       = 32;
   localparam int CHANNELS        = 2;
   localparam int STAGES          = 3;

   localparam int COEF_INDEX_BITS = 5;
   localparam int COEF_VALUE_BITS = 32;

   localparam int FRAC_BITS       = COEF_BITS - 4;
   localparam int BIQUADS         = CHANNELS * STAGES;
   localparam int COEF_PER_BQ     = 5;
   localparam int HIST_PER_BQ     = 4;
   localparam int COEF_SLOTS      = BIQUADS * COEF_PER_BQ;
   localparam int HIST_SLOTS      = BIQUADS * HIST_PER_BQ;
   localparam int COEF_ADDR_BITS  = $clog2(COEF_SLOTS);
   localparam int HIST_ADDR_BITS  = $clog2(HIST_SLOTS);
   localparam int ST_BITS         = (STAGES > 1) ? $clog2(STAGES) : 1;
   localparam int CH_BITS         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam int PROD_BITS       = COEF_BITS + SAMPLE_BITS;
   localparam int ACC_BITS        = (PROD_BITS + 3 > 64) ? 64 : PROD_BITS + 3;

   localparam logic CMD_FRAME      = 1'b0;
   localparam logic CMD_COEF_WRITE = 1'b1;

   localparam logic signed [COEF_BITS-1:0] COEF_ONE =
      {{(COEF_BITS-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

endpackage

@@ rtl/core/stbeq_ifs.sv @@
// ----------------------------------------------------------------------------
// stbeq request and response channels
// Valid/ready channels carrying equalizer requests and filtered frames.
// ----------------------------------------------------------------------------
interface stbeq_req_if;
   import stbeq_pkg::*;

   logic                              valid;
   logic                              ready;
   logic                              command;
   logic signed [SAMPLE_BITS-1:0]     left_sample;
   logic signed [SAMPLE_BITS-1:0]     right_sample;
   logic                              block_end;
   logic [COEF_INDEX_BITS-1:0]        coef_index;
   logic signed [COEF_VALUE_BITS-1:0] coef_value;

   modport source (
      output valid, command, left_sample, right_sample, block_end, coef_index, coef_value,
      input  ready
   );

   modport sink (
      input  valid, command, left_sample, right_sample, block_end, coef_index, coef_value,
      output ready
   );
endinterface

interface stbeq_rsp_if;
   import stbeq_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_out;
   logic signed [SAMPLE_BITS-1:0] right_out;
   logic                          block_end_out;

   modport source (
      output valid, left_out, right_out, block_end_out,
      input  ready
   );

   modport sink (
      input  valid, left_out, right_out, block_end_out,
      output ready
   );
endinterface

@@ rtl/core/stereo_three_band_biquad_eq.sv @@
// ----------------------------------------------------------------------------
// stereo_three_band_biquad_eq
// Stereo equalizer: three cascaded direct-form-1 biquads per channel.
// ----------------------------------------------------------------------------
// A frame request is filtered by one shared multiply-accumulate unit that
// walks the biquads in order, reading coefficients and history from two
// single-read-port memories. Each biquad occupies the unit for five
// coefficient reads plus the multiplier and accumulator stages, and a frame
// holds off the next request from acceptance until its last biquad result
// has been written back. A coefficient write request gives no response.
// The response sits in an output register, and a new request is accepted
// while it waits. Both memories come out of reset ready to use, with no
// clearing pass.
module stereo_three_band_biquad_eq (
   input  logic         clock,
   input  logic         reset,
   stbeq_req_if.sink    req_if,
   stbeq_rsp_if.source  rsp_if
);
   import stbeq_pkg::*;

   localparam int STEP_BITS = 3;
   localparam logic [STEP_BITS-1:0] STEP_FIRST      = 3'd0;
   localparam logic [STEP_BITS-1:0] STEP_X_TERM     = 3'd1;
   localparam logic [STEP_BITS-1:0] STEP_FIRST_HIST = 3'd1;
   localparam logic [STEP_BITS-1:0] STEP_X1_SHIFT   = 3'd2;
   localparam logic [STEP_BITS-1:0] STEP_X_WRITE    = 3'd3;
   localparam logic [STEP_BITS-1:0] STEP_Y1_SHIFT   = 3'd4;
   localparam logic [STEP_BITS-1:0] STEP_FIRST_SUB  = 3'd4;
   localparam logic [STEP_BITS-1:0] STEP_LAST_ISSUE = 3'd4;
   localparam logic [STEP_BITS-1:0] STEP_LAST_MUL   = 3'd5;
   localparam logic [STEP_BITS-1:0] STEP_LAST       = 3'd6;

   localparam int HIST_X1 = 0;
   localparam int HIST_X2 = 1;
   localparam int HIST_Y1 = 2;
   localparam int HIST_Y2 = 3;

   localparam logic signed [ACC_BITS-1:0] ACC_ROUND =
      {{(ACC_BITS-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
   localparam logic signed [ACC_BITS-1:0] SAT_HI =
      {{(ACC_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [ACC_BITS-1:0] SAT_LO =
      {{(ACC_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

   typedef struct packed {
      logic                      valid;
      logic                      final_bq;
      logic                      last_stage;
      logic [CH_BITS-1:0]        ch;
      logic [HIST_ADDR_BITS-1:0] y1_addr;
   } tail_type;

   // sequencer
   logic                      run_ff, run_in;
   logic [STEP_BITS-1:0]      step_ff, step_in;
   logic [ST_BITS-1:0]        st_ff, st_in;
   logic [CH_BITS-1:0]        ch_ff, ch_in;
   logic [COEF_ADDR_BITS-1:0] cbase_ff, cbase_in;
   logic [HIST_ADDR_BITS-1:0] hbase_ff, hbase_in;
   tail_type                  tail_ff, tail_in;

   logic req_fire, frame_fire, coef_fire;
   logic last_stage, last_bq;
   logic out_free, out_load;

   // memories
   logic signed [COEF_BITS-1:0]   coef_mem [COEF_SLOTS];
   logic signed [SAMPLE_BITS-1:0] hist_mem [HIST_SLOTS];
   logic [COEF_SLOTS-1:0]         coef_vld_ff;
   logic [HIST_SLOTS-1:0]         hist_vld_ff;
   logic signed [COEF_BITS-1:0]   coef_rd_ff;
   logic signed [SAMPLE_BITS-1:0] hist_rd_ff;

   logic                          coef_re;
   logic [COEF_ADDR_BITS-1:0]     coef_raddr, coef_waddr;
   logic signed [COEF_BITS-1:0]   coef_wdata;
   logic                          hist_re, hist_we;
   logic [HIST_ADDR_BITS-1:0]     hist_raddr, hist_waddr;
   logic signed [SAMPLE_BITS-1:0] hist_wdata;

   // datapath
   logic signed [SAMPLE_BITS-1:0] x_ff, right_ff;
   logic                          block_end_ff;
   logic signed [SAMPLE_BITS-1:0] mul_data;
   logic                          mul_en;
   logic signed [PROD_BITS-1:0]   prod_ff, prod_in;
   logic                          prod_vld_ff, prod_first_ff, prod_sub_ff;
   logic signed [ACC_BITS-1:0]    acc_ff, acc_base, acc_round, acc_shift;
   logic signed [SAMPLE_BITS-1:0] y_val, next_sample;
   logic signed [SAMPLE_BITS-1:0] res_left_ff, res_right_ff;
   logic signed [SAMPLE_BITS-1:0] rsp_left_ff, rsp_right_ff;
   logic                          rsp_block_end_ff, rsp_valid_ff;

   // handshake
   assign req_if.ready = !reset && !run_ff && !tail_ff.valid;
   assign req_fire     = req_if.valid && req_if.ready;
   assign frame_fire   = req_fire && (req_if.command == CMD_FRAME);
   assign coef_fire    = req_fire && (req_if.command == CMD_COEF_WRITE) &&
                         (32'(req_if.coef_index) < COEF_SLOTS);

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign out_load = tail_ff.valid && tail_ff.final_bq && out_free;

   assign last_stage = (st_ff == ST_BITS'(STAGES - 1));
   assign last_bq    = last_stage && (ch_ff == CH_BITS'(CHANNELS - 1));

   always_comb begin
      run_in   = run_ff;
      step_in  = step_ff;
      st_in    = st_ff;
      ch_in    = ch_ff;
      cbase_in = cbase_ff;
      hbase_in = hbase_ff;
      tail_in  = tail_ff;
      if (tail_ff.valid && (!tail_ff.final_bq || out_free)) begin
         tail_in.valid = 1'b0;
      end
      if (frame_fire) begin
         run_in   = 1'b1;
         step_in  = STEP_FIRST;
         st_in    = '0;
         ch_in    = '0;
         cbase_in = '0;
         hbase_in = '0;
      end else if (run_ff) begin
         if (step_ff == STEP_LAST) begin
            step_in            = STEP_FIRST;
            tail_in.valid      = 1'b1;
            tail_in.final_bq   = last_bq;
            tail_in.last_stage = last_stage;
            tail_in.ch         = ch_ff;
            tail_in.y1_addr    = hbase_ff + HIST_ADDR_BITS'(HIST_Y1);
            cbase_in           = cbase_ff + COEF_ADDR_BITS'(COEF_PER_BQ);
            hbase_in           = hbase_ff + HIST_ADDR_BITS'(HIST_PER_BQ);
            if (last_bq) begin
               run_in = 1'b0;
            end else if (last_stage) begin
               st_in = '0;
               ch_in = ch_ff + CH_BITS'(1);
            end else begin
               st_in = st_ff + ST_BITS'(1);
            end
         end else begin
            step_in = step_ff + STEP_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         step_ff  <= STEP_FIRST;
         st_ff    <= '0;
         ch_ff    <= '0;
         cbase_ff <= '0;
         hbase_ff <= '0;
         tail_ff  <= '0;
      end else begin
         run_ff   <= run_in;
         step_ff  <= step_in;
         st_ff    <= st_in;
         ch_ff    <= ch_in;
         cbase_ff <= cbase_in;
         hbase_ff <= hbase_in;
         tail_ff  <= tail_in;
      end
   end

   // coefficient memory; unwritten entries read as unity b0, zero elsewhere
   assign coef_re    = run_ff && (step_ff <= STEP_LAST_ISSUE);
   assign coef_raddr = cbase_ff + COEF_ADDR_BITS'(step_ff);
   assign coef_waddr = COEF_ADDR_BITS'(req_if.coef_index);
   assign coef_wdata = COEF_BITS'(req_if.coef_value);

   always_ff @(posedge clock) begin
      if (coef_fire) begin
         coef_mem[coef_waddr] <= coef_wdata;
      end
      if (coef_re) begin
         if (coef_vld_ff[coef_raddr]) begin
            coef_rd_ff <= coef_mem[coef_raddr];
         end else if (step_ff == STEP_FIRST) begin
            coef_rd_ff <= COEF_ONE;
         end else begin
            coef_rd_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_vld_ff <= '0;
      end else if (coef_fire) begin
         coef_vld_ff[coef_waddr] <= 1'b1;
      end
   end

   // history memory: x1, x2, y1, y2 per biquad, unwritten entries read zero
   assign hist_re    = run_ff && (step_ff >= STEP_FIRST_HIST) && (step_ff <= STEP_LAST_ISSUE);
   assign hist_raddr = hbase_ff + HIST_ADDR_BITS'(step_ff - STEP_FIRST_HIST);

   always_comb begin
      hist_we    = 1'b0;
      hist_waddr = hbase_ff;
      hist_wdata = hist_rd_ff;
      priority if (tail_ff.valid) begin
         hist_we    = 1'b1;
         hist_waddr = tail_ff.y1_addr;
         hist_wdata = y_val;
      end else if (run_ff && (step_ff == STEP_X1_SHIFT)) begin
         hist_we    = 1'b1;
         hist_waddr = hbase_ff + HIST_ADDR_BITS'(HIST_X2);
      end else if (run_ff && (step_ff == STEP_X_WRITE)) begin
         hist_we    = 1'b1;
         hist_waddr = hbase_ff + HIST_ADDR_BITS'(HIST_X1);
         hist_wdata = x_ff;
      end else if (run_ff && (step_ff == STEP_Y1_SHIFT)) begin
         hist_we    = 1'b1;
         hist_waddr = hbase_ff + HIST_ADDR_BITS'(HIST_Y2);
      end
   end

   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem[hist_waddr] <= hist_wdata;
      end
      if (hist_re) begin
         if (hist_vld_ff[hist_raddr]) begin
            hist_rd_ff <= hist_mem[hist_raddr];
         end else begin
            hist_rd_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_vld_ff <= '0;
      end else if (hist_we) begin
         hist_vld_ff[hist_waddr] <= 1'b1;
      end
   end

   // multiply-accumulate
   assign mul_en   = run_ff && (step_ff >= STEP_X_TERM) && (step_ff <= STEP_LAST_MUL);
   assign mul_data = (step_ff == STEP_X_TERM) ? x_ff : hist_rd_ff;
   assign prod_in  = coef_rd_ff * mul_data;
   assign acc_base = prod_first_ff ? '0 : acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= mul_en;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff       <= prod_in;
         prod_first_ff <= (step_ff == STEP_X_TERM);
         prod_sub_ff   <= (step_ff >= STEP_FIRST_SUB);
      end
      if (prod_vld_ff) begin
         if (prod_sub_ff) begin
            acc_ff <= acc_base - ACC_BITS'(prod_ff);
         end else begin
            acc_ff <= acc_base + ACC_BITS'(prod_ff);
         end
      end
   end

   // round half up, then saturate
   assign acc_round = acc_ff + ACC_ROUND;
   assign acc_shift = acc_round >>> FRAC_BITS;

   always_comb begin
      priority if (acc_shift > SAT_HI) begin
         y_val = SAT_HI[SAMPLE_BITS-1:0];
      end else if (acc_shift < SAT_LO) begin
         y_val = SAT_LO[SAMPLE_BITS-1:0];
      end else begin
         y_val = acc_shift[SAMPLE_BITS-1:0];
      end
   end

   assign next_sample = (tail_ff.ch == CH_BITS'(0)) ? right_ff : '0;

   always_ff @(posedge clock) begin
      if (frame_fire) begin
         x_ff         <= req_if.left_sample;
         right_ff     <= req_if.right_sample;
         block_end_ff <= req_if.block_end;
         res_right_ff <= '0;
      end else if (tail_ff.valid) begin
         if (tail_ff.last_stage) begin
            x_ff <= next_sample;
            if (tail_ff.ch == CH_BITS'(0)) begin
               res_left_ff <= y_val;
            end
            if (tail_ff.ch == CH_BITS'(1)) begin
               res_right_ff <= y_val;
            end
         end else begin
            x_ff <= y_val;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_left_ff      <= (tail_ff.ch == CH_BITS'(0)) ? y_val : res_left_ff;
         rsp_right_ff     <= (tail_ff.ch == CH_BITS'(1)) ? y_val : res_right_ff;
         rsp_block_end_ff <= block_end_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.left_out      = rsp_left_ff;
   assign rsp_if.right_out     = rsp_right_ff;
   assign rsp_if.block_end_out = rsp_block_end_ff;

endmodule

@@ bench/stereo_three_band_biquad_eq_tb.sv @@
// ----------------------------------------------------------------------------
// stereo_three_band_biquad_eq_tb
// Self-checking bench for the stereo three-band biquad equalizer. Requests are
// frames and coefficient writes. A scoreboard keeps its own coefficient and
// history copies, predicts every filtered frame and checks each response in
// order. Both channels stall at random.
// ----------------------------------------------------------------------------
module stereo_three_band_biquad_eq_tb;
   import stbeq_pkg::*;

   localparam int IDLE_PCT   = 18;
   localparam int DRAIN_WAIT = 50;
   localparam int WDOG_LIMIT = 4000;

   typedef struct packed {
      logic                              command;
      logic signed [SAMPLE_BITS-1:0]     left_sample;
      logic signed [SAMPLE_BITS-1:0]     right_sample;
      logic                              block_end;
      logic [COEF_INDEX_BITS-1:0]        coef_index;
      logic signed [COEF_VALUE_BITS-1:0] coef_value;
   } eq_request_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] left_out;
      logic signed [SAMPLE_BITS-1:0] right_out;
      logic                          block_end_out;
   } eq_frame_type;

   class eq_frame_checker;
      logic signed [COEF_BITS-1:0]   coefs [COEF_SLOTS];
      logic signed [SAMPLE_BITS-1:0] hist  [HIST_SLOTS];
      eq_frame_type                  pending_frames [$];
      int                            error_count;

      function new();
         for (int i = 0; i < COEF_SLOTS; i++) begin
            coefs[i] = (i % COEF_PER_BQ == 0) ? COEF_ONE : '0;
         end
         for (int i = 0; i < HIST_SLOTS; i++) begin
            hist[i] = '0;
         end
         error_count = 0;
      endfunction

      task report(string msg);
         $display("ERROR @%0t: %s", $realtime, msg);
         error_count++;
      endtask

      function int pending();
         return pending_frames.size();
      endfunction

      // One DF1 section: exact 64-bit sum, round half up, saturate.
      function logic signed [SAMPLE_BITS-1:0] filter_stage(int bq,
                                                           logic signed [SAMPLE_BITS-1:0] x);
         longint acc;
         longint hi;
         longint lo;
         int     c;
         int     h;
         c   = bq * COEF_PER_BQ;
         h   = bq * HIST_PER_BQ;
         acc = longint'(coefs[c])     * longint'(x)
             + longint'(coefs[c + 1]) * longint'(hist[h])
             + longint'(coefs[c + 2]) * longint'(hist[h + 1])
             - longint'(coefs[c + 3]) * longint'(hist[h + 2])
             - longint'(coefs[c + 4]) * longint'(hist[h + 3]);
         acc = acc + (longint'(1) <<< (FRAC_BITS - 1));
         acc = acc >>> FRAC_BITS;
         hi  = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
         lo  = -hi - 1;
         if (acc > hi) acc = hi;
         if (acc < lo) acc = lo;
         hist[h + 1] = hist[h];
         hist[h]     = x;
         hist[h + 3] = hist[h + 2];
         hist[h + 2] = acc[SAMPLE_BITS-1:0];
         return acc[SAMPLE_BITS-1:0];
      endfunction

      function void accept_request(eq_request_type r);
         eq_frame_type                  f;
         logic signed [SAMPLE_BITS-1:0] v;
         if (r.command == CMD_COEF_WRITE) begin
            if (r.coef_index < COEF_SLOTS) coefs[r.coef_index] = r.coef_value;
            return;
         end
         f = '0;
         for (int ch = 0; ch < CHANNELS; ch++) begin
            v = (ch == 0) ? r.left_sample : (ch == 1) ? r.right_sample : '0;
            for (int st = 0; st < STAGES; st++) begin
               v = filter_stage(ch * STAGES + st, v);
            end
            if (ch == 0) f.left_out = v;
            if (ch == 1) f.right_out = v;
         end
         f.block_end_out = r.block_end;
         pending_frames.push_back(f);
      endfunction

      task check_frame(eq_frame_type got);
         eq_frame_type exp_f;
         if (pending_frames.size() == 0) begin
            report("response with no frame outstanding");
            return;
         end
         exp_f = pending_frames.pop_front();
         if (got.left_out !== exp_f.left_out)
            report($sformatf("left_out %0d, expected %0d", got.left_out, exp_f.left_out));
         if (got.right_out !== exp_f.right_out)
            report($sformatf("right_out %0d, expected %0d", got.right_out, exp_f.right_out));
         if (got.block_end_out !== exp_f.block_end_out)
            report($sformatf("block_end_out %0b, expected %0b",
                             got.block_end_out, exp_f.block_end_out));
      endtask
   endclass

   logic clock;
   logic reset;
   logic steady;

   stbeq_req_if req_bus ();
   stbeq_rsp_if rsp_bus ();

   eq_frame_checker scoreboard = new();

   stereo_three_band_biquad_eq DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic eq_request_type frame_req(int l, int r, bit be);
      eq_request_type q;
      q              = '0;
      q.command      = CMD_FRAME;
      q.left_sample  = l[SAMPLE_BITS-1:0];
      q.right_sample = r[SAMPLE_BITS-1:0];
      q.block_end    = be;
      q.coef_index   = COEF_INDEX_BITS'($urandom());
      q.coef_value   = $urandom();
      return q;
   endfunction

   function automatic eq_request_type write_req(int idx, int val);
      eq_request_type q;
      q              = '0;
      q.command      = CMD_COEF_WRITE;
      q.left_sample  = SAMPLE_BITS'($urandom());
      q.right_sample = SAMPLE_BITS'($urandom());
      q.block_end    = 1'($urandom_range(1));
      q.coef_index   = idx[COEF_INDEX_BITS-1:0];
      q.coef_value   = val;
      return q;
   endfunction

   function automatic int rand_sample();
      case ($urandom_range(9))
         0:       return (1 << (SAMPLE_BITS - 1)) - 1;
         1:       return -(1 << (SAMPLE_BITS - 1));
         2, 3, 4: return int'($urandom_range(1 << 21)) - (1 << 20);
         default: return int'($urandom());
      endcase
   endfunction

   // b taps within +-1.0, a1 within +-0.5, a2 within +-0.25: stable sections
   function automatic int design_coef(int k);
      int span;
      span = (k < 3) ? (1 << FRAC_BITS) : (k == 3) ? (1 << (FRAC_BITS - 1))
                                                   : (1 << (FRAC_BITS - 2));
      return int'($urandom_range(2 * span)) - span;
   endfunction

   task send_request(eq_request_type r);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.command      <= r.command;
      req_bus.left_sample  <= r.left_sample;
      req_bus.right_sample <= r.right_sample;
      req_bus.block_end    <= r.block_end;
      req_bus.coef_index   <= r.coef_index;
      req_bus.coef_value   <= r.coef_value;
      do @(posedge clock); while (!req_bus.ready);
      scoreboard.accept_request(r);
   endtask

   task drain_frames();
      req_bus.valid <= 1'b0;
      while (scoreboard.pending() != 0) @(posedge clock);
   endtask

   // response side
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            scoreboard.check_frame({rsp_bus.left_out, rsp_bus.right_out,
                                    rsp_bus.block_end_out});
         rsp_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // watchdog: cycles with no request and no response accepted
   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= WDOG_LIMIT) begin
            $display("timeout: no request or response accepted in %0d cycles", WDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      reset                = 1'b1;
      steady               = 1'b0;
      req_bus.valid        = 1'b0;
      req_bus.command      = CMD_FRAME;
      req_bus.left_sample  = '0;
      req_bus.right_sample = '0;
      req_bus.block_end    = 1'b0;
      req_bus.coef_index   = '0;
      req_bus.coef_value   = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // identity response out of reset
      send_request(frame_req((1 << (SAMPLE_BITS - 1)) - 1, -(1 << (SAMPLE_BITS - 1)), 1'b1));
      send_request(frame_req(-(1 << (SAMPLE_BITS - 1)), (1 << (SAMPLE_BITS - 1)) - 1, 1'b0));
      send_request(frame_req(0, 0, 1'b1));
      send_request(frame_req(-1, 1, 1'b0));
      // out-of-range slots are ignored
      send_request(write_req(30, 32'h7FFF_FFFF));
      send_request(write_req(31, 32'h8000_0000));
      send_request(frame_req(12345, -12345, 1'b0));
      // extreme gains drive saturation both ways
      send_request(write_req(0, 32'h7FFF_FFFF));
      send_request(write_req(15, 32'h8000_0000));
      send_request(frame_req((1 << (SAMPLE_BITS - 1)) - 1, (1 << (SAMPLE_BITS - 1)) - 1, 1'b1));
      send_request(frame_req(-(1 << (SAMPLE_BITS - 1)), -(1 << (SAMPLE_BITS - 1)), 1'b0));
      // feed-forward and feedback taps on the left low shelf
      send_request(write_req(0, COEF_ONE));
      send_request(write_req(1, COEF_ONE));
      send_request(write_req(2, -COEF_ONE));
      send_request(write_req(3, COEF_ONE >>> 1));
      send_request(write_req(4, -(COEF_ONE >>> 2)));
      send_request(frame_req(4000000, -4000000, 1'b0));
      send_request(frame_req(0, 0, 1'b1));
      send_request(write_req(15, COEF_ONE));
      send_request(frame_req(100, -100, 1'b0));
      drain_frames();

      for (int phase = 0; phase < 10; phase++) begin
         steady <= (phase == 4);
         if (phase == 6) drain_frames();
         for (int k = 0; k < COEF_SLOTS; k++) begin
            send_request(write_req(k, design_coef(k % COEF_PER_BQ)));
         end
         repeat (40) begin
            if ($urandom_range(99) < 10) begin
               int idx;
               idx = $urandom_range(31);
               send_request(write_req(idx, $urandom_range(1) ? int'($urandom())
                                                             : design_coef(idx % COEF_PER_BQ)));
            end else begin
               send_request(frame_req(rand_sample(), rand_sample(), 1'($urandom_range(1))));
            end
         end
      end

      steady <= 1'b0;
      drain_frames();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (scoreboard.error_count == 0 && scoreboard.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
